>>> hdl/diff_drive_mix_slew_limiter_core_assert.svh
// ----------------------------------------------------------------------------
// diff_drive_mix_slew_limiter_core assertion macros
// Clocked assertion wrappers for the checker file of the block.
// ----------------------------------------------------------------------------
`ifndef DIFF_DRIVE_MIX_SLEW_LIMITER_CORE_ASSERT_SVH
`define DIFF_DRIVE_MIX_SLEW_LIMITER_CORE_ASSERT_SVH

// property checked on every rising edge outside reset
`define DDMSL_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// property checked on every rising edge, reset included
`define DDMSL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/ddmsl_pkg.sv
// ----------------------------------------------------------------------------
// ddmsl_pkg
// Shared widths, register map, reset values and types of the mixer core.
// ----------------------------------------------------------------------------
package ddmsl_pkg;

  // field widths
  localparam int unsigned REF_W      = 16;
  localparam int unsigned FSR_W      = 9;
  localparam int unsigned Q8_W       = 16;
  localparam int unsigned MV_W       = 16;
  localparam int unsigned SPD_W      = 18;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  // default depth of the command queue
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MV_GAIN     = 8'd3;

  // register reset values
  localparam logic [FSR_W-1:0] FSR_RESET      = 9'd160;
  localparam logic [Q8_W-1:0]  SPD_LIM_RESET  = 16'd20480;
  localparam logic [Q8_W-1:0]  STEP_LIM_RESET = 16'd1024;
  localparam logic [Q8_W-1:0]  MV_GAIN_RESET  = 16'd19200;

  // configuration register file
  typedef struct packed {
    logic [FSR_W-1:0] full_scale_rpm;
    logic [Q8_W-1:0]  speed_limit_q8;
    logic [Q8_W-1:0]  step_limit_q8;
    logic [Q8_W-1:0]  mv_per_rpm_q8;
  } cfg_regs_t;

  // one queued command
  typedef struct packed {
    logic signed [REF_W-1:0] speed_ref;
    logic signed [REF_W-1:0] turn_ref;
  } cmd_item_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // back end sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_W,
    ST_MIX,
    ST_SLEW,
    ST_MUL_L,
    ST_MUL_R,
    ST_DONE
  } back_state_t;

endpackage

>>> hdl/ddmsl_ifs.sv
// ----------------------------------------------------------------------------
// ddmsl channel interfaces
// Valid/ready channels for commands, drive results and register writes.
// ----------------------------------------------------------------------------
interface ddmsl_cmd_if;
  import ddmsl_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [REF_W-1:0] speed_ref;
  logic signed [REF_W-1:0] turn_ref;
  modport source (output valid, speed_ref, turn_ref, input ready);
  modport sink (input valid, speed_ref, turn_ref, output ready);
endinterface

interface ddmsl_drv_if;
  import ddmsl_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [MV_W-1:0] left_mv;
  logic signed [MV_W-1:0] right_mv;
  modport source (output valid, left_mv, right_mv, input ready);
  modport sink (input valid, left_mv, right_mv, output ready);
endinterface

interface ddmsl_cfg_if;
  import ddmsl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/ddmsl_fifo.sv
// ----------------------------------------------------------------------------
// ddmsl_fifo
// Small command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ddmsl_fifo #(
  parameter int unsigned DEPTH = ddmsl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  ddmsl_pkg::cmd_item_t  din,
  input  logic                  pop,
  output ddmsl_pkg::cmd_item_t  dout,
  output ddmsl_pkg::q_status_t  status
);
  import ddmsl_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_item_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  // status and guarded strobes
  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign dout         = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/ddmsl_front.sv
// ----------------------------------------------------------------------------
// ddmsl_front
// Takes commands into the queue and holds the configuration registers.
// ----------------------------------------------------------------------------
module ddmsl_front (
  input  logic                 clk,
  input  logic                 rst,
  ddmsl_cmd_if.sink            cmd,
  ddmsl_cfg_if.sink            cfg,
  input  ddmsl_pkg::q_status_t q_status,
  output logic                 q_push,
  output ddmsl_pkg::cmd_item_t q_data,
  output ddmsl_pkg::cfg_regs_t regs
);
  import ddmsl_pkg::*;

  // command side: accept while the queue has room
  assign cmd.ready        = !q_status.full;
  assign q_push           = cmd.valid && !q_status.full;
  assign q_data.speed_ref = cmd.speed_ref;
  assign q_data.turn_ref  = cmd.turn_ref;

  // register writes are always taken
  assign cfg.ready = 1'b1;

  // register file, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.full_scale_rpm <= FSR_RESET;
      regs.speed_limit_q8 <= SPD_LIM_RESET;
      regs.step_limit_q8  <= STEP_LIM_RESET;
      regs.mv_per_rpm_q8  <= MV_GAIN_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_FULL_SCALE:  regs.full_scale_rpm <= cfg.data[FSR_W-1:0];
        REG_SPEED_LIMIT: regs.speed_limit_q8 <= cfg.data[Q8_W-1:0];
        REG_STEP_LIMIT:  regs.step_limit_q8  <= cfg.data[Q8_W-1:0];
        REG_MV_GAIN:     regs.mv_per_rpm_q8  <= cfg.data[Q8_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> hdl/ddmsl_back.sv
// ----------------------------------------------------------------------------
// ddmsl_back
// Mixes, clamps and slews the wheel speeds and scales them to millivolts
// through one shared multiplier.
// ----------------------------------------------------------------------------
module ddmsl_back (
  input  logic                 clk,
  input  logic                 rst,
  input  ddmsl_pkg::q_status_t q_status,
  input  ddmsl_pkg::cmd_item_t q_data,
  input  ddmsl_pkg::cfg_regs_t regs,
  output logic                 q_pop,
  ddmsl_drv_if.source          drv
);
  import ddmsl_pkg::*;

  localparam int unsigned PROD_W = SPD_W + Q8_W + 1;
  localparam int unsigned SUM_W  = SPD_W + 1;

  back_state_t              state;
  back_state_t              state_next;
  logic signed [SPD_W-1:0]  mul_a;
  logic [Q8_W-1:0]          mul_b;
  logic signed [PROD_W-1:0] ext_a;
  logic signed [PROD_W-1:0] ext_b;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [PROD_W-1:0] prod;
  logic signed [REF_W-1:0]  turn_hold;
  logic signed [SPD_W-1:0]  v_q;
  logic signed [SPD_W-1:0]  w_cur;
  logic signed [SPD_W-1:0]  left_tgt;
  logic signed [SPD_W-1:0]  right_tgt;
  logic signed [SPD_W-1:0]  left_prev;
  logic signed [SPD_W-1:0]  right_prev;
  logic signed [MV_W-1:0]   left_hold;
  logic                     load_out;
  logic                     out_valid;
  logic signed [MV_W-1:0]   out_left;
  logic signed [MV_W-1:0]   out_right;

  // symmetric clamp of a wide difference to +/- lim
  function automatic logic signed [SPD_W-1:0] clamp_sym(
    input logic signed [SUM_W-1:0] x,
    input logic [Q8_W-1:0]         lim
  );
    logic signed [SUM_W-1:0] pos;
    logic signed [SUM_W-1:0] neg;
    pos = SUM_W'(lim);
    neg = -pos;
    if (x > pos) begin
      return SPD_W'(pos);
    end else if (x < neg) begin
      return SPD_W'(neg);
    end
    return SPD_W'(x);
  endfunction

  // step from prev toward tgt by at most lim
  function automatic logic signed [SPD_W-1:0] slew(
    input logic signed [SPD_W-1:0] tgt,
    input logic signed [SPD_W-1:0] prev,
    input logic [Q8_W-1:0]         lim
  );
    logic signed [SUM_W-1:0] diff;
    logic signed [SPD_W-1:0] d;
    logic signed [SUM_W-1:0] nxt;
    diff = SUM_W'(tgt) - SUM_W'(prev);
    d    = clamp_sym(diff, lim);
    nxt  = SUM_W'(prev) + SUM_W'(d);
    return SPD_W'(nxt);
  endfunction

  // floor shift by 16 and saturate to 16 bits
  function automatic logic signed [MV_W-1:0] sat_mv(
    input logic signed [PROD_W-1:0] p
  );
    logic [PROD_W-17:0] m;
    m = p[PROD_W-1:16];
    if (m[PROD_W-17:MV_W-1] == '0 || m[PROD_W-17:MV_W-1] == '1) begin
      return $signed(m[MV_W-1:0]);
    end else if (m[PROD_W-17]) begin
      return 16'sh8000;
    end
    return 16'sh7fff;
  endfunction

  // shared multiplier, registered
  assign ext_a     = PROD_W'(mul_a);
  assign ext_b     = PROD_W'(mul_b);
  assign prod_next = ext_a * ext_b;
  assign w_cur     = $signed(prod[SPD_W+6:7]);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (!q_status.empty) state_next = ST_MUL_W;
      ST_MUL_W: state_next = ST_MIX;
      ST_MIX:   state_next = ST_SLEW;
      ST_SLEW:  state_next = ST_MUL_L;
      ST_MUL_L: state_next = ST_MUL_R;
      ST_MUL_R: state_next = ST_DONE;
      ST_DONE:  if (!out_valid || drv.ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs and multiplier operand select
  always_comb begin
    q_pop    = (state == ST_IDLE) && !q_status.empty;
    load_out = (state == ST_DONE) && (!out_valid || drv.ready);
    unique case (state)
      ST_IDLE: begin
        mul_a = SPD_W'(q_data.speed_ref);
        mul_b = Q8_W'(regs.full_scale_rpm);
      end
      ST_MUL_W: begin
        mul_a = SPD_W'(turn_hold);
        mul_b = Q8_W'(regs.full_scale_rpm);
      end
      ST_MUL_R: begin
        mul_a = right_prev;
        mul_b = regs.mv_per_rpm_q8;
      end
      default: begin
        mul_a = left_prev;
        mul_b = regs.mv_per_rpm_q8;
      end
    endcase
  end

  // state and wheel speed memory
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      left_prev  <= '0;
      right_prev <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SLEW) begin
        left_prev  <= slew(left_tgt, left_prev, regs.step_limit_q8);
        right_prev <= slew(right_tgt, right_prev, regs.step_limit_q8);
      end
    end
  end

  // datapath registers, the right wheel product holds while a result waits
  always_ff @(posedge clk) begin
    if (state != ST_DONE) begin
      prod <= prod_next;
    end
    if (q_pop) begin
      turn_hold <= q_data.turn_ref;
    end
    if (state == ST_MUL_W) begin
      v_q <= $signed(prod[SPD_W+6:7]);
    end
    if (state == ST_MIX) begin
      left_tgt  <= clamp_sym(SUM_W'(v_q) - SUM_W'(w_cur), regs.speed_limit_q8);
      right_tgt <= clamp_sym(SUM_W'(v_q) + SUM_W'(w_cur), regs.speed_limit_q8);
    end
    if (state == ST_MUL_R) begin
      left_hold <= sat_mv(prod);
    end
    if (load_out) begin
      out_left  <= left_hold;
      out_right <= sat_mv(prod);
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (drv.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign drv.valid    = out_valid;
  assign drv.left_mv  = out_left;
  assign drv.right_mv = out_right;

endmodule

>>> hdl/diff_drive_mix_slew_limiter_core.sv
// ----------------------------------------------------------------------------
// diff_drive_mix_slew_limiter_core
// Differential drive mixer with per-wheel slew limiting and voltage scaling.
// ----------------------------------------------------------------------------
// Each command (speed_ref, turn_ref, signed Q1.15) yields one result
// (left_mv, right_mv, signed millivolts saturated to 16 bits). Commands are
// scaled to 1/256 rpm by full_scale_rpm, mixed into left = v - omega and
// right = v + omega, clamped to +/- speed_limit_q8, moved from the stored
// wheel speed by at most step_limit_q8 and scaled by mv_per_rpm_q8. A command
// queue lets new commands in while the back end works and a result waits in
// the output register. The back end handles one command at a time, in four
// products sharing one 18 x 17 multiplier plus the mix, slew and load steps,
// and pops the next only once its result is loaded. Register writes are taken
// at any time and should only be made while no command is in flight.
module diff_drive_mix_slew_limiter_core #(
  parameter int unsigned QUEUE_DEPTH = ddmsl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ddmsl_cmd_if.sink   cmd,
  ddmsl_cfg_if.sink   cfg,
  ddmsl_drv_if.source drv
);
  import ddmsl_pkg::*;

  q_status_t q_status;
  cmd_item_t q_din;
  cmd_item_t q_dout;
  cfg_regs_t regs;
  logic      q_push;
  logic      q_pop;

  // accept and configure
  ddmsl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg      (cfg),
    .q_status (q_status),
    .q_push   (q_push),
    .q_data   (q_din),
    .regs     (regs)
  );

  // command queue
  ddmsl_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .din    (q_din),
    .pop    (q_pop),
    .dout   (q_dout),
    .status (q_status)
  );

  // compute and deliver
  ddmsl_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .q_data   (q_dout),
    .regs     (regs),
    .q_pop    (q_pop),
    .drv      (drv)
  );

endmodule

>>> hdl/ddmsl_chk.sv
// ----------------------------------------------------------------------------
// ddmsl_chk
// Port level checks of the mixer core, bound to the top level.
// ----------------------------------------------------------------------------
`include "diff_drive_mix_slew_limiter_core_assert.svh"

module ddmsl_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           cmd_ready,
  input logic                           cfg_ready,
  input logic                           drv_valid,
  input logic                           drv_ready,
  input logic signed [ddmsl_pkg::MV_W-1:0] drv_left_mv,
  input logic signed [ddmsl_pkg::MV_W-1:0] drv_right_mv
);
  import ddmsl_pkg::*;

  // a waiting result stays until its transfer
  `DDMSL_ASSERT_CLK(a_drv_valid_hold, drv_valid && !drv_ready |=> drv_valid, "result withdrawn")

  // a stalled result keeps its value
  `DDMSL_ASSERT_CLK(a_drv_data_hold, drv_valid && !drv_ready |=> $stable(drv_left_mv) && $stable(drv_right_mv), "stalled result changed")

  // reset leaves no result and a queue with room
  `DDMSL_ASSERT_RST(a_reset_clean, rst |=> !drv_valid && cmd_ready, "not clean after reset")

  // register writes are never back-pressured
  `DDMSL_ASSERT_RST(a_cfg_ready, !rst |-> cfg_ready, "register write stalled")

endmodule

bind diff_drive_mix_slew_limiter_core ddmsl_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .cmd_ready    (cmd.ready),
  .cfg_ready    (cfg.ready),
  .drv_valid    (drv.valid),
  .drv_ready    (drv.ready),
  .drv_left_mv  (drv.left_mv),
  .drv_right_mv (drv.right_mv)
);

>>> tb/sv/diff_drive_mix_slew_limiter_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// diff_drive_mix_slew_limiter_core_tb
// Self-checking bench for the differential drive mixer core. Commands go in
// over the command channel, and every drive result is checked field by field
// against a cycle-free predictor of the mix, clamp, slew and voltage scaling.
// Register settings change between phases. Both channel ends idle at random,
// and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module diff_drive_mix_slew_limiter_core_tb;
  import ddmsl_pkg::*;

  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned HOLD_CYCLES   = 120;
  localparam int unsigned SETTLE_CYCLES = 20;

  typedef struct packed {
    logic signed [MV_W-1:0] left_mv;
    logic signed [MV_W-1:0] right_mv;
  } wheel_mv_t;

  logic clk = 1'b0;
  logic rst;

  ddmsl_cmd_if cmd_ch ();
  ddmsl_cfg_if cfg_ch ();
  ddmsl_drv_if drv_ch ();

  diff_drive_mix_slew_limiter_core u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .cfg (cfg_ch),
    .drv (drv_ch)
  );

  // predictor state and register shadow
  cfg_regs_t               shadow_cfg;
  logic signed [SPD_W-1:0] left_speed_q8;
  logic signed [SPD_W-1:0] right_speed_q8;
  wheel_mv_t               drive_expect_q[$];

  int unsigned fail_count  = 0;
  int unsigned idle_cycles = 0;
  bit          tx_idle_en  = 1'b1;
  bit          rx_idle_en  = 1'b1;
  bit          hold_req    = 1'b0;

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Q1.15 reference to 1/256 rpm, floor
  function automatic longint scale_ref(input logic signed [REF_W-1:0] r);
    longint p;
    p = longint'(r) * longint'(shadow_cfg.full_scale_rpm);
    return p >>> 7;
  endfunction

  function automatic longint clamp_mag(input longint x, input longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  // move toward target by at most the step limit
  function automatic logic signed [SPD_W-1:0] slew_step(input longint target,
                                                        input logic signed [SPD_W-1:0] prev);
    longint d;
    d = clamp_mag(target - longint'(prev), longint'(shadow_cfg.step_limit_q8));
    return SPD_W'(longint'(prev) + d);
  endfunction

  // wheel speed to saturated millivolts, floor
  function automatic logic signed [MV_W-1:0] speed_to_mv(input logic signed [SPD_W-1:0] spd);
    longint p;
    p = (longint'(spd) * longint'(shadow_cfg.mv_per_rpm_q8)) >>> 16;
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    return MV_W'(p);
  endfunction

  // full step of the drive: mix, clamp, slew, store, scale
  function automatic wheel_mv_t mix_and_slew(input logic signed [REF_W-1:0] speed,
                                             input logic signed [REF_W-1:0] turn);
    longint    v;
    longint    w;
    longint    lim;
    wheel_mv_t res;
    v   = scale_ref(speed);
    w   = scale_ref(turn);
    lim = longint'(shadow_cfg.speed_limit_q8);
    left_speed_q8  = slew_step(clamp_mag(v - w, lim), left_speed_q8);
    right_speed_q8 = slew_step(clamp_mag(v + w, lim), right_speed_q8);
    res.left_mv  = speed_to_mv(left_speed_q8);
    res.right_mv = speed_to_mv(right_speed_q8);
    return res;
  endfunction

  // random reference: full range, small values or extremes
  function automatic logic signed [REF_W-1:0] rand_ref();
    logic signed [REF_W-1:0] r;
    case ($urandom_range(0, 3))
      0, 1: r = REF_W'($urandom);
      2: r = REF_W'($urandom_range(0, 4095)) - 16'sd2048;
      default: begin
        case ($urandom_range(0, 4))
          0: r = 16'sh7FFF;
          1: r = 16'sh8000;
          2: r = 16'sd0;
          3: r = -16'sd1;
          default: r = 16'sd1;
        endcase
      end
    endcase
    return r;
  endfunction

  // one command transfer; valid stays high for the next command
  task automatic send_cmd(input logic signed [REF_W-1:0] speed,
                          input logic signed [REF_W-1:0] turn);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.speed_ref <= speed;
    cmd_ch.turn_ref  <= turn;
    do @(posedge clk); while (!cmd_ch.ready);
    drive_expect_q.push_back(mix_and_slew(speed, turn));
  endtask

  // one register write transfer; valid is left high
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_FULL_SCALE:  shadow_cfg.full_scale_rpm = val[FSR_W-1:0];
      REG_SPEED_LIMIT: shadow_cfg.speed_limit_q8 = val[Q8_W-1:0];
      REG_STEP_LIMIT:  shadow_cfg.step_limit_q8  = val[Q8_W-1:0];
      REG_MV_GAIN:     shadow_cfg.mv_per_rpm_q8  = val[Q8_W-1:0];
      default: ;
    endcase
  endtask

  // stop offering commands and wait for every pending result
  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (drive_expect_q.size() != 0);
  endtask

  // write all four registers while idle
  task automatic load_config(input logic [CFG_DATA_W-1:0] fsr,
                             input logic [CFG_DATA_W-1:0] spd_lim,
                             input logic [CFG_DATA_W-1:0] step_lim,
                             input logic [CFG_DATA_W-1:0] gain);
    wait_drained();
    write_reg(REG_FULL_SCALE, fsr);
    write_reg(REG_SPEED_LIMIT, spd_lim);
    write_reg(REG_STEP_LIMIT, step_lim);
    write_reg(REG_MV_GAIN, gain);
    cfg_ch.valid <= 1'b0;
  endtask

  // reset register values with field extremes, slew ramps from standstill
  task automatic test_reset_defaults();
    send_cmd(16'sh7FFF, 16'sd0);
    send_cmd(16'sh8000, 16'sd0);
    send_cmd(16'sd0, 16'sh7FFF);
    send_cmd(16'sd0, 16'sh8000);
    send_cmd(16'sh7FFF, 16'sh7FFF);
    send_cmd(16'sh8000, 16'sh8000);
    send_cmd(16'sh7FFF, 16'sh8000);
    send_cmd(16'sh8000, 16'sh7FFF);
    send_cmd(-16'sd1, -16'sd1);
    send_cmd(16'sd1, 16'sd1);
    wait_drained();
  endtask

  // unused indexes, wide data, frozen slew, zero clamp, floor of negatives
  task automatic test_register_writes();
    write_reg(8'd4, 16'h1234);
    write_reg(8'hFF, 16'hFFFF);
    write_reg(REG_FULL_SCALE, 16'hFFFF);
    write_reg(REG_SPEED_LIMIT, 16'hFFFF);
    write_reg(REG_STEP_LIMIT, 16'hFFFF);
    write_reg(REG_MV_GAIN, 16'hFFFF);
    cfg_ch.valid <= 1'b0;
    send_cmd(16'sh7FFF, 16'sh8000);
    send_cmd(16'sh8000, 16'sh7FFF);
    send_cmd(-16'sd1, 16'sd1);
    // zero step limit holds both wheels
    load_config(16'd511, 16'hFFFF, 16'd0, 16'hFFFF);
    send_cmd(16'sh7FFF, 16'sd0);
    send_cmd(16'sh8000, 16'sh7FFF);
    // zero speed limit slews both wheels to standstill
    load_config(16'd511, 16'd0, 16'd700, 16'd19200);
    send_cmd(16'sh7FFF, 16'sh7FFF);
    send_cmd(16'sh8000, 16'sd5);
    send_cmd(16'sd100, -16'sd100);
    // small negative products round toward minus infinity
    load_config(16'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_cmd(-16'sd1, 16'sd0);
    send_cmd(-16'sd129, -16'sd1);
    wait_drained();
  endtask

  // random commands under a series of register settings
  task automatic test_random_settings();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: load_config(16'(FSR_RESET), SPD_LIM_RESET, STEP_LIM_RESET, MV_GAIN_RESET);
        1: load_config(16'd511, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: load_config(16'd0, 16'd30000, 16'd2000, 16'd40000);
        3: load_config(16'd200, 16'd0, 16'd300, 16'd19200);
        4: load_config(16'd300, 16'd50000, 16'd0, 16'd19200);
        5: load_config(16'($urandom), 16'($urandom), 16'($urandom_range(1, 4096)),
                       16'($urandom));
        default: load_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      repeat (100) send_cmd(rand_ref(), rand_ref());
    end
    wait_drained();
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_backpressure();
    load_config(16'd256, 16'd40000, 16'd3000, 16'd25000);
    tx_idle_en = 1'b0;
    hold_req   = 1'b1;
    repeat (40) send_cmd(rand_ref(), rand_ref());
    tx_idle_en = 1'b1;
    wait_drained();
  endtask

  // back to back transfers with no idling at either end
  task automatic test_full_rate();
    load_config(16'($urandom), 16'($urandom), 16'($urandom_range(0, 8000)), 16'($urandom));
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (250) send_cmd(rand_ref(), rand_ref());
    wait_drained();
  endtask

  // result receiver: random stall bursts and the long hold-off
  initial begin
    drv_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        drv_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        drv_ch.ready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        drv_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        drv_ch.ready <= 1'b1;
      end else begin
        drv_ch.ready <= 1'b1;
      end
    end
  end

  // result check against the oldest pending expectation
  always @(posedge clk) begin
    wheel_mv_t want;
    if (!rst && drv_ch.valid && drv_ch.ready) begin
      if (drive_expect_q.size() == 0) begin
        $display("%0t unexpected result: left_mv %0d right_mv %0d",
                 $time, drv_ch.left_mv, drv_ch.right_mv);
        fail_count++;
      end else begin
        want = drive_expect_q.pop_front();
        if (drv_ch.left_mv !== want.left_mv) begin
          $display("%0t left_mv: expected %0d actual %0d",
                   $time, want.left_mv, drv_ch.left_mv);
          fail_count++;
        end
        if (drv_ch.right_mv !== want.right_mv) begin
          $display("%0t right_mv: expected %0d actual %0d",
                   $time, want.right_mv, drv_ch.right_mv);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (drv_ch.valid && drv_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("diff_drive_mix_slew_limiter_core: mismatch");
        $finish;
      end
    end
  end

  // sequence of tests
  initial begin
    rst              = 1'b1;
    cmd_ch.valid     = 1'b0;
    cmd_ch.speed_ref = '0;
    cmd_ch.turn_ref  = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    shadow_cfg.full_scale_rpm = FSR_RESET;
    shadow_cfg.speed_limit_q8 = SPD_LIM_RESET;
    shadow_cfg.step_limit_q8  = STEP_LIM_RESET;
    shadow_cfg.mv_per_rpm_q8  = MV_GAIN_RESET;
    left_speed_q8  = '0;
    right_speed_q8 = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_register_writes();
    test_random_settings();
    test_backpressure();
    test_full_rate();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && drive_expect_q.size() == 0) begin
      $display("diff_drive_mix_slew_limiter_core: match");
    end else begin
      $display("diff_drive_mix_slew_limiter_core: mismatch");
    end
    $finish;
  end

endmodule
